[hdl/rls_pkg.sv]
// Shared types, constants and saturation helpers for the RLS adaptive filter.
// Used by rls_mul, rls_div and rls_adaptive_filter; depends on nothing else.
package rls_pkg;

	localparam logic signed [47:0] LIM48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [63:0] LIM48_W = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic [15:0] INIT_RESET = 16'd1000;
	localparam logic [15:0] INIT_SAT = 16'd32767;

	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_READ    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_WAIT,
		ST_DIV,
		ST_DIVW,
		ST_SUMS,
		ST_SUMS2,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_PU,
		PH_DEN,
		PH_FO1,
		PH_WUPD,
		PH_FO2,
		PH_V,
		PH_PUPD
	} phase_t;

	typedef struct packed {
		logic start;
		logic long_b;
		logic sh32;
	} mul_ctl_t;

	function automatic logic [47:0] mag48(input logic signed [47:0] v);
		return v[47] ? 48'(-v) : 48'(v);
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		if (v > LIM48_W) begin
			return LIM48;
		end
		if (v < -LIM48_W) begin
			return -LIM48;
		end
		return v[47:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] diag_of(input logic [15:0] init);
		return (init > INIT_SAT) ? LIM48 : {init, 32'b0};
	endfunction

endpackage

[hdl/rls_mul.sv]
// Multi-cycle rounding multiplier: 48-bit by 16-bit partial products, then
// rounding to nearest (ties away from zero) and symmetric 48-bit saturation.
// Depends on rls_pkg.
module rls_mul
	import rls_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  mul_ctl_t            ctl,
	input  logic signed [47:0]  a,
	input  logic signed [47:0]  b,
	output logic                done,
	output logic signed [47:0]  res
);

	logic               busy_q;
	logic               rnd_q;
	logic               done_q;
	logic [1:0]         cnt_q;
	logic [47:0]        ma_q;
	logic [47:0]        mb_q;
	logic               neg_q;
	logic               sh32_q;
	logic [95:0]        acc_q;
	logic signed [47:0] res_q;
	logic [15:0]        chunk;
	logic [63:0]        part;
	logic [96:0]        rsum;
	logic [96:0]        rshift;
	logic [46:0]        rmag;

	always_comb begin
		unique case (cnt_q)
			2'd2: begin
				chunk = mb_q[47:32];
			end
			2'd1: begin
				chunk = mb_q[31:16];
			end
			default: begin
				chunk = mb_q[15:0];
			end
		endcase
		part   = {16'b0, ma_q} * {48'b0, chunk};
		rsum   = {1'b0, acc_q} + (sh32_q ? (97'd1 << 31) : (97'd1 << 14));
		rshift = sh32_q ? (rsum >> 32) : (rsum >> 15);
		rmag   = (rshift > 97'h7FFF_FFFF_FFFF) ? LIM48[46:0] : rshift[46:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= ctl.long_b ? 2'd2 : 2'd0;
		end else if (busy_q && !rnd_q) begin
			done_q <= 1'b0;
			if (cnt_q == 2'd0) begin
				rnd_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 2'd1;
			end
		end else if (busy_q) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			ma_q   <= mag48(a);
			mb_q   <= mag48(b);
			neg_q  <= a[47] ^ b[47];
			sh32_q <= ctl.sh32;
			acc_q  <= '0;
		end else if (busy_q && !rnd_q) begin
			acc_q <= (acc_q << 16) + {32'b0, part};
		end else if (busy_q) begin
			res_q <= neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[hdl/rls_div.sv]
// Restoring divider for the gain: trunc(num * 2^32 / den), one quotient bit
// per cycle, saturated symmetrically to 48 bits.
// Depends on rls_pkg.
module rls_div
	import rls_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [47:0]  num,
	input  logic signed [48:0]  den,
	output logic                done,
	output logic signed [47:0]  quo
);

	logic               busy_q;
	logic               fin_q;
	logic               done_q;
	logic [6:0]         cnt_q;
	logic [47:0]        n_q;
	logic [48:0]        d_q;
	logic [49:0]        r_q;
	logic [48:0]        q_q;
	logic               over_q;
	logic               neg_q;
	logic signed [47:0] quo_q;
	logic [49:0]        r_sh;
	logic               ge;
	logic [49:0]        r_nx;
	logic [48:0]        q_sh;
	logic [47:0]        qm;

	always_comb begin
		r_sh = {r_q[48:0], n_q[47]};
		ge   = r_sh >= {1'b0, d_q};
		r_nx = ge ? (r_sh - {1'b0, d_q}) : r_sh;
		q_sh = {q_q[47:0], ge};
		qm   = over_q ? 48'(LIM48) : q_q[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd79;
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= mag48(num);
			d_q    <= den[48:0];
			r_q    <= '0;
			q_q    <= '0;
			over_q <= 1'b0;
			neg_q  <= num[47];
		end else if (busy_q) begin
			n_q <= n_q << 1;
			r_q <= r_nx;
			if (!over_q) begin
				q_q    <= q_sh;
				over_q <= q_sh > 49'h7FFF_FFFF_FFFF;
			end
		end else if (fin_q) begin
			quo_q <= neg_q ? -$signed(qm) : $signed(qm);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hdl/rls_adaptive_filter.sv]
// Top level of the RLS adaptive FIR identifier: sequencer, P matrix memory,
// tap line, weights and running sums. Depends on rls_pkg, rls_mul, rls_div.
//
// One transaction is taken at a time. For a sample, every P element
// is read from the single-port matrix memory and goes through the one shared
// multiplier three times (P*u, u'*P and the update), and each of the TAPS
// gains comes from a divide when the denominator is positive, else it is zero.
// After reset, and after a restart, a clear pass writes all TAPS^2 matrix
// elements before the next transaction is taken; a restart returns its result
// at the end of that pass.
module rls_adaptive_filter
	import rls_pkg::*;
#(
	parameter int TAPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,      // init_inverse_delta
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,       // sample_in, desired, weight_index, zero pad
	input  logic [1:0]   s_tuser,       // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [223:0] m_tdata,       // prior_error, posterior_error,
	                                    // error_product_sum, desired_energy,
	                                    // weight_value, zero pad
	output logic [1:0]   m_tuser        // result_kind
);

	localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int DEPTH = TAPS * TAPS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACCW = 49 + $clog2(TAPS);

	state_t             state_q, state_d;
	phase_t             phase_q;
	op_t                op_q;
	logic [IW-1:0]      i_q, j_q;
	logic [15:0]        init_q;
	logic signed [47:0] diag_q;
	logic signed [15:0] tap_q [TAPS];
	logic signed [47:0] w_q [TAPS];
	logic signed [47:0] pu_q [TAPS];
	logic signed [47:0] v_q [TAPS];
	logic signed [63:0] psum_q;
	logic [62:0]        esum_q;
	logic signed [ACCW-1:0] acc_q;
	logic signed [48:0] den_q;
	logic signed [31:0] prior_q, post_q;
	logic signed [15:0] dx_q;
	logic [5:0]         idx_q;
	logic signed [63:0] prod_q;
	logic [31:0]        e2_q;
	logic signed [47:0] mem [DEPTH];
	logic signed [47:0] rdata_q;
	logic               m_tvalid_q;
	logic [1:0]         kind_q;
	logic [31:0]        oprior_q, opost_q, oweight_q;
	logic [63:0]        opsum_q;
	logic [62:0]        oesum_q;

	logic               accept;
	op_t                in_op;
	logic               i_last, j_last;
	logic [AW-1:0]      addr;
	logic               mem_we;
	logic signed [47:0] mem_wdata;
	mul_ctl_t           mul_ctl;
	logic               mul_start;
	logic signed [47:0] mul_a, mul_b, mul_res;
	logic               mul_done;
	logic               div_start, div_done;
	logic signed [47:0] div_quo;
	logic signed [ACCW-1:0] acc_sum;
	logic signed [47:0] acc_sat;
	logic signed [63:0] dq64;
	logic signed [31:0] err;
	logic               den_pos;
	logic signed [64:0] psum_ext;
	logic [63:0]        esum_ext;
	logic signed [31:0] wsel;
	logic               out_load;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_op     = op_t'(s_tuser);
	assign i_last    = (i_q == IW'(TAPS - 1));
	assign j_last    = (j_q == IW'(TAPS - 1));
	assign addr      = AW'(32'(i_q) * TAPS + 32'(j_q));
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		acc_sum  = acc_q + ACCW'(mul_res);
		acc_sat  = sat48(64'(acc_sum));
		dq64     = {{39{dx_q[15]}}, dx_q, 9'b0};
		err      = sat32(dq64 - 64'(acc_sat));
		den_pos  = !den_q[48] && (den_q != '0);
		psum_ext = 65'(psum_q) + 65'(prod_q);
		esum_ext = {1'b0, esum_q} + {32'b0, e2_q};
		wsel     = (32'(idx_q) < TAPS) ? sat32(64'(w_q[idx_q[IW-1:0]])) : '0;
		if (state_q == ST_CLEAR) begin
			mem_wdata = (i_q == j_q) ? diag_q : '0;
		end else begin
			mem_wdata = sat48(64'(rdata_q) - 64'(mul_res));
		end
	end

	always_comb begin
		mul_ctl.start  = mul_start;
		mul_ctl.long_b = 1'b0;
		mul_ctl.sh32   = 1'b0;
		mul_a          = w_q[i_q];
		mul_b          = 48'(tap_q[i_q]);
		unique case (phase_q)
			PH_PU: begin
				mul_a = rdata_q;
				mul_b = 48'(tap_q[j_q]);
			end
			PH_DEN: begin
				mul_a = pu_q[i_q];
			end
			PH_FO1, PH_FO2: begin
				mul_a = w_q[i_q];
			end
			PH_WUPD: begin
				mul_a          = pu_q[i_q];
				mul_b          = 48'(prior_q);
				mul_ctl.long_b = 1'b1;
				mul_ctl.sh32   = 1'b1;
			end
			PH_V: begin
				mul_a = rdata_q;
			end
			PH_PUPD: begin
				mul_a          = pu_q[i_q];
				mul_b          = v_q[j_q];
				mul_ctl.long_b = 1'b1;
				mul_ctl.sh32   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		mem_we    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (i_last && j_last) begin
					state_d = (op_q == OP_RESTART) ? ST_OUT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (in_op)
						OP_SAMPLE: begin
							state_d = ST_RD;
						end
						OP_READ: begin
							state_d = ST_OUT;
						end
						OP_RESTART: begin
							state_d = ST_CLEAR;
						end
						OP_NONE: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RD: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				mul_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (mul_done) begin
					mem_we = (phase_q == PH_PUPD);
					if (phase_q == PH_DEN && i_last) begin
						state_d = ST_DIV;
					end else if (phase_q == PH_PUPD && i_last && j_last) begin
						state_d = ST_SUMS;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_DIV: begin
				if (den_pos) begin
					div_start = 1'b1;
					state_d   = ST_DIVW;
				end else if (i_last) begin
					state_d = ST_RD;
				end
			end
			ST_DIVW: begin
				if (div_done) begin
					state_d = i_last ? ST_RD : ST_DIV;
				end
			end
			ST_SUMS: begin
				state_d = ST_SUMS2;
			end
			ST_SUMS2: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= mem_wdata;
		end
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PU;
			op_q    <= OP_NONE;
			i_q     <= '0;
			j_q     <= '0;
			init_q  <= INIT_RESET;
			diag_q  <= diag_of(INIT_RESET);
			psum_q  <= '0;
			esum_q  <= '0;
			for (int t = 0; t < TAPS; t++) begin
				tap_q[t] <= '0;
				w_q[t]   <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				init_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= in_op;
						i_q  <= '0;
						j_q  <= '0;
						if (in_op == OP_SAMPLE) begin
							phase_q <= PH_PU;
							for (int t = TAPS - 1; t > 0; t--) begin
								tap_q[t] <= tap_q[t-1];
							end
							tap_q[0] <= s_tdata[15:0];
						end else if (in_op == OP_RESTART) begin
							diag_q <= diag_of(init_q);
							psum_q <= '0;
							esum_q <= '0;
							for (int t = 0; t < TAPS; t++) begin
								tap_q[t] <= '0;
								w_q[t]   <= '0;
							end
						end
					end
				end
				ST_CLEAR: begin
					if (j_last) begin
						j_q <= '0;
						i_q <= i_last ? '0 : i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (mul_done) begin
						unique case (phase_q)
							PH_PU, PH_PUPD: begin
								if (j_last) begin
									j_q <= '0;
									if (i_last) begin
										i_q     <= '0;
										phase_q <= PH_DEN;
									end else begin
										i_q <= i_q + 1'b1;
									end
								end else begin
									j_q <= j_q + 1'b1;
								end
							end
							PH_DEN: begin
								i_q <= i_last ? '0 : i_q + 1'b1;
							end
							PH_FO1: begin
								i_q <= i_last ? '0 : i_q + 1'b1;
								if (i_last) begin
									phase_q <= PH_WUPD;
								end
							end
							PH_WUPD: begin
								w_q[i_q] <= sat48(64'(w_q[i_q]) + 64'(mul_res));
								i_q      <= i_last ? '0 : i_q + 1'b1;
								if (i_last) begin
									phase_q <= PH_FO2;
								end
							end
							PH_FO2: begin
								i_q <= i_last ? '0 : i_q + 1'b1;
								if (i_last) begin
									j_q     <= '0;
									phase_q <= PH_V;
								end
							end
							PH_V: begin
								if (i_last) begin
									i_q <= '0;
									if (j_last) begin
										j_q     <= '0;
										phase_q <= PH_PUPD;
									end else begin
										j_q <= j_q + 1'b1;
									end
								end else begin
									i_q <= i_q + 1'b1;
								end
							end
						endcase
					end
				end
				ST_DIV: begin
					if (!den_pos) begin
						i_q <= i_last ? '0 : i_q + 1'b1;
						if (i_last) begin
							phase_q <= PH_FO1;
						end
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						i_q <= i_last ? '0 : i_q + 1'b1;
						if (i_last) begin
							phase_q <= PH_FO1;
						end
					end
				end
				ST_SUMS2: begin
					if (psum_ext > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
						psum_q <= 64'sh7FFF_FFFF_FFFF_FFFF;
					end else if (psum_ext < -65'sh0_8000_0000_0000_0000) begin
						psum_q <= 64'sh8000_0000_0000_0000;
					end else begin
						psum_q <= psum_ext[63:0];
					end
					esum_q <= esum_ext[63] ? {63{1'b1}} : esum_ext[62:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q  <= s_tdata[31:16];
			idx_q <= s_tdata[37:32];
			acc_q <= '0;
		end
		if (state_q == ST_WAIT && mul_done) begin
			unique case (phase_q)
				PH_PU: begin
					if (j_last) begin
						pu_q[i_q] <= acc_sat;
						acc_q     <= '0;
					end else begin
						acc_q <= acc_sum;
					end
				end
				PH_DEN: begin
					if (i_last) begin
						den_q <= 49'(acc_sat) + 49'sh1_0000_0000;
						acc_q <= '0;
					end else begin
						acc_q <= acc_sum;
					end
				end
				PH_FO1: begin
					if (i_last) begin
						prior_q <= err;
						acc_q   <= '0;
					end else begin
						acc_q <= acc_sum;
					end
				end
				PH_FO2: begin
					if (i_last) begin
						post_q <= err;
						acc_q  <= '0;
					end else begin
						acc_q <= acc_sum;
					end
				end
				PH_V: begin
					if (i_last) begin
						v_q[j_q] <= acc_sat;
						acc_q    <= '0;
					end else begin
						acc_q <= acc_sum;
					end
				end
				PH_WUPD, PH_PUPD: begin
					acc_q <= '0;
				end
			endcase
		end
		if (state_q == ST_DIV && !den_pos) begin
			pu_q[i_q] <= '0;
		end
		if (state_q == ST_DIVW && div_done) begin
			pu_q[i_q] <= div_quo;
		end
		if (state_q == ST_SUMS) begin
			prod_q <= 64'(prior_q) * 64'(post_q);
			e2_q   <= 32'(32'(dx_q) * 32'(dx_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q    <= op_q;
			oprior_q  <= (op_q == OP_SAMPLE) ? prior_q : '0;
			opost_q   <= (op_q == OP_SAMPLE) ? post_q : '0;
			opsum_q   <= psum_q;
			oesum_q   <= esum_q;
			oweight_q <= (op_q == OP_READ) ? wsel : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {1'b0, oweight_q, oesum_q, opsum_q, opost_q, oprior_q};

	rls_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	rls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (pu_q[i_q]),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

`ifndef SYNTH
	a_mem_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || (state_q == ST_WAIT && phase_q == PH_PUPD)))
		else $error("Matrix memory written outside the clear pass or the update phase.");

	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_WAIT))
		else $error("Multiplier finished while the sequencer was not waiting for it.");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVW))
		else $error("Divider finished while the sequencer was not waiting for it.");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("Result register loaded without raising its valid.");
`endif

endmodule
